/* hw/rtl/dsi_pkg.sv */
package dsi_pkg;

  localparam int MAX_SUBSTEP_COUNT = 32;
  localparam int SUBSTEP_RATE_HZ   = 240;

  localparam int DATA_W   = 32;
  localparam int OMEGA_W  = 24;
  localparam int ZETA_W   = 16;
  localparam int FT_W     = 24;
  localparam int H_SHIFT  = 8;
  localparam int H_W      = FT_W + H_SHIFT;
  localparam int STEP_W   = $clog2(MAX_SUBSTEP_COUNT + 1);
  localparam int NEED_W   = FT_W + 13;

  localparam int IN_TDATA_W  = 3 * DATA_W + OMEGA_W + ZETA_W;
  localparam int OUT_TDATA_W = 2 * DATA_W;

  localparam int VAL_W = 56;
  localparam int MUL_W = 32;
  localparam int HI_W  = VAL_W - MUL_W;
  localparam int ACC_W = VAL_W + MUL_W;

  localparam int UPC_W = 5;

  typedef logic [3:0]       act_t;
  typedef logic [1:0]       src_t;
  typedef logic [1:0]       mb_t;
  typedef logic [1:0]       sh_t;
  typedef logic [2:0]       dst_t;
  typedef logic [UPC_W-1:0] upc_t;

  localparam act_t ACT_CHK  = 4'd0;
  localparam act_t ACT_DIFF = 4'd1;
  localparam act_t ACT_SUB  = 4'd2;
  localparam act_t ACT_LOAD = 4'd3;
  localparam act_t ACT_MLO  = 4'd4;
  localparam act_t ACT_MHI  = 4'd5;
  localparam act_t ACT_WB   = 4'd6;
  localparam act_t ACT_LOOP = 4'd7;
  localparam act_t ACT_DONE = 4'd8;

  localparam src_t SRC_W  = 2'd0;
  localparam src_t SRC_T1 = 2'd1;
  localparam src_t SRC_V  = 2'd2;
  localparam src_t SRC_D1 = 2'd3;

  localparam mb_t MB_OMEGA = 2'd0;
  localparam mb_t MB_ZETA  = 2'd1;
  localparam mb_t MB_H     = 2'd2;

  localparam sh_t SH_14 = 2'd0;
  localparam sh_t SH_11 = 2'd1;
  localparam sh_t SH_32 = 2'd2;

  localparam dst_t DST_T1 = 3'd0;
  localparam dst_t DST_T2 = 3'd1;
  localparam dst_t DST_D1 = 3'd2;
  localparam dst_t DST_D2 = 3'd3;
  localparam dst_t DST_V  = 3'd4;
  localparam dst_t DST_X  = 3'd5;

  localparam upc_t UA_TOP  = 5'd1;
  localparam upc_t UA_DONE = 5'd28;

  typedef struct packed {
    logic              zero;
    logic [STEP_W-1:0] steps;
    logic [H_W-1:0]    h;
  } frame_t;

  typedef struct packed {
    act_t act;
    src_t src;
    mb_t  mb;
    sh_t  sh;
    dst_t dst;
    upc_t target;
  } uword_t;

  function automatic uword_t uw(input act_t act, input src_t src, input mb_t mb,
                                input sh_t sh, input dst_t dst, input upc_t target);
    uword_t w;
    w.act    = act;
    w.src    = src;
    w.mb     = mb;
    w.sh     = sh;
    w.dst    = dst;
    w.target = target;
    return w;
  endfunction

  // One substep runs from address 1 to address 27; address 0 skips a zero frame.
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    case (addr)
      5'd0:    w = uw(ACT_CHK,  SRC_W,  MB_OMEGA, SH_14, DST_T1, UA_DONE);
      5'd1:    w = uw(ACT_DIFF, SRC_W,  MB_OMEGA, SH_14, DST_T1, UA_TOP);
      5'd2:    w = uw(ACT_LOAD, SRC_W,  MB_OMEGA, SH_14, DST_T1, UA_TOP);
      5'd3:    w = uw(ACT_MLO,  SRC_W,  MB_OMEGA, SH_14, DST_T1, UA_TOP);
      5'd4:    w = uw(ACT_MHI,  SRC_W,  MB_OMEGA, SH_14, DST_T1, UA_TOP);
      5'd5:    w = uw(ACT_WB,   SRC_W,  MB_OMEGA, SH_14, DST_T1, UA_TOP);
      5'd6:    w = uw(ACT_LOAD, SRC_T1, MB_OMEGA, SH_14, DST_T2, UA_TOP);
      5'd7:    w = uw(ACT_MLO,  SRC_T1, MB_OMEGA, SH_14, DST_T2, UA_TOP);
      5'd8:    w = uw(ACT_MHI,  SRC_T1, MB_OMEGA, SH_14, DST_T2, UA_TOP);
      5'd9:    w = uw(ACT_WB,   SRC_T1, MB_OMEGA, SH_14, DST_T2, UA_TOP);
      5'd10:   w = uw(ACT_LOAD, SRC_V,  MB_OMEGA, SH_14, DST_D1, UA_TOP);
      5'd11:   w = uw(ACT_MLO,  SRC_V,  MB_OMEGA, SH_14, DST_D1, UA_TOP);
      5'd12:   w = uw(ACT_MHI,  SRC_V,  MB_OMEGA, SH_14, DST_D1, UA_TOP);
      5'd13:   w = uw(ACT_WB,   SRC_V,  MB_OMEGA, SH_14, DST_D1, UA_TOP);
      5'd14:   w = uw(ACT_LOAD, SRC_D1, MB_ZETA,  SH_11, DST_D2, UA_TOP);
      5'd15:   w = uw(ACT_MLO,  SRC_D1, MB_ZETA,  SH_11, DST_D2, UA_TOP);
      5'd16:   w = uw(ACT_MHI,  SRC_D1, MB_ZETA,  SH_11, DST_D2, UA_TOP);
      5'd17:   w = uw(ACT_WB,   SRC_D1, MB_ZETA,  SH_11, DST_D2, UA_TOP);
      5'd18:   w = uw(ACT_SUB,  SRC_W,  MB_H,     SH_32, DST_V,  UA_TOP);
      5'd19:   w = uw(ACT_LOAD, SRC_W,  MB_H,     SH_32, DST_V,  UA_TOP);
      5'd20:   w = uw(ACT_MLO,  SRC_W,  MB_H,     SH_32, DST_V,  UA_TOP);
      5'd21:   w = uw(ACT_MHI,  SRC_W,  MB_H,     SH_32, DST_V,  UA_TOP);
      5'd22:   w = uw(ACT_WB,   SRC_W,  MB_H,     SH_32, DST_V,  UA_TOP);
      5'd23:   w = uw(ACT_LOAD, SRC_V,  MB_H,     SH_32, DST_X,  UA_TOP);
      5'd24:   w = uw(ACT_MLO,  SRC_V,  MB_H,     SH_32, DST_X,  UA_TOP);
      5'd25:   w = uw(ACT_MHI,  SRC_V,  MB_H,     SH_32, DST_X,  UA_TOP);
      5'd26:   w = uw(ACT_WB,   SRC_V,  MB_H,     SH_32, DST_X,  UA_TOP);
      5'd27:   w = uw(ACT_LOOP, SRC_W,  MB_H,     SH_32, DST_X,  UA_TOP);
      default: w = uw(ACT_DONE, SRC_W,  MB_H,     SH_32, DST_X,  UA_TOP);
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/dsi_div.sv */
module dsi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dsi_pkg::FT_W-1:0]  frame_time,
  output logic                      busy,
  output dsi_pkg::frame_t           frame
);

  localparam int CNT_W = $clog2(dsi_pkg::H_W);
  localparam int RAW_W = dsi_pkg::NEED_W - dsi_pkg::FT_W + 1;

  logic [dsi_pkg::NEED_W-1:0]   need;
  logic [dsi_pkg::NEED_W:0]     need_up;
  logic [RAW_W-1:0]             raw;
  logic [dsi_pkg::STEP_W-1:0]   steps_new;
  logic [dsi_pkg::STEP_W-1:0]   steps;
  logic [dsi_pkg::STEP_W-1:0]   rem;
  logic [dsi_pkg::STEP_W:0]     trial;
  logic [dsi_pkg::STEP_W:0]     trial_sub;
  logic                         fits;
  logic [dsi_pkg::H_W-1:0]      q;
  logic [CNT_W-1:0]             cnt;
  logic                         zero;

  assign need    = dsi_pkg::NEED_W'(frame_time) * dsi_pkg::NEED_W'(dsi_pkg::SUBSTEP_RATE_HZ);
  assign need_up = (dsi_pkg::NEED_W + 1)'(need) +
                   (dsi_pkg::NEED_W + 1)'((1 << dsi_pkg::FT_W) - 1);
  assign raw     = need_up[dsi_pkg::NEED_W:dsi_pkg::FT_W];

  always_comb begin
    priority if (raw == '0) begin
      steps_new = dsi_pkg::STEP_W'(1);
    end else if (raw > RAW_W'(dsi_pkg::MAX_SUBSTEP_COUNT)) begin
      steps_new = dsi_pkg::STEP_W'(dsi_pkg::MAX_SUBSTEP_COUNT);
    end else begin
      steps_new = raw[dsi_pkg::STEP_W-1:0];
    end
  end

  // Restoring division of the scaled frame time by the substep count, one bit a cycle.
  assign trial     = {rem, q[dsi_pkg::H_W-1]};
  assign fits      = trial >= {1'b0, steps};
  assign trial_sub = trial - {1'b0, steps};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      zero <= 1'b1;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      zero <= (frame_time == '0);
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(dsi_pkg::H_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dsi_pkg::H_W'(frame_time) << dsi_pkg::H_SHIFT;
      rem   <= '0;
      steps <= steps_new;
    end else if (busy) begin
      q   <= {q[dsi_pkg::H_W-2:0], fits};
      rem <= fits ? trial_sub[dsi_pkg::STEP_W-1:0] : trial[dsi_pkg::STEP_W-1:0];
    end
  end

  assign frame.zero  = zero;
  assign frame.steps = steps;
  assign frame.h     = q;

endmodule

/* hw/rtl/dsi_core.sv */
module dsi_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [dsi_pkg::DATA_W-1:0] position,
  input  logic signed [dsi_pkg::DATA_W-1:0] velocity,
  input  logic signed [dsi_pkg::DATA_W-1:0] target,
  input  logic [dsi_pkg::OMEGA_W-1:0]       stiffness_omega,
  input  logic [dsi_pkg::ZETA_W-1:0]        damping_ratio,
  input  logic                              last_in_batch,
  input  dsi_pkg::frame_t                   frame,
  output logic                              busy,
  output logic                              done_valid,
  input  logic                              done_ready,
  output logic signed [dsi_pkg::DATA_W-1:0] new_position,
  output logic signed [dsi_pkg::DATA_W-1:0] new_velocity,
  output logic                              batch_end
);

  localparam int VW = dsi_pkg::VAL_W;
  localparam int DW = dsi_pkg::DATA_W;
  localparam int MW = dsi_pkg::MUL_W;

  function automatic logic signed [DW-1:0] sat(input logic signed [VW:0] s);
    if (&s[VW:DW-1] || ~|s[VW:DW-1]) begin
      return s[DW-1:0];
    end else if (s[VW]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  dsi_pkg::upc_t   upc;
  dsi_pkg::uword_t uwc;

  logic signed [DW-1:0]              x, v, tgt;
  logic [dsi_pkg::OMEGA_W-1:0]       om;
  logic [dsi_pkg::ZETA_W-1:0]        ze;
  logic                              last;
  logic signed [VW-1:0]              w, t1, t2, d1, d2;
  logic [VW-1:0]                     mag;
  logic                              sgn;
  logic [dsi_pkg::ACC_W-1:0]         acc;
  logic [dsi_pkg::STEP_W-1:0]        k;
  logic [dsi_pkg::STEP_W-1:0]        k_inc;

  logic signed [VW-1:0]              x_ext, v_ext, tgt_ext;
  logic signed [VW-1:0]              diff, acc_diff, src_val;
  logic [VW-1:0]                     src_abs;
  logic [MW-1:0]                     mul_a, mul_b;
  logic [2*MW-1:0]                   prod;
  logic [dsi_pkg::ACC_W-1:0]         acc_sh;
  logic [VW-1:0]                     res_mag;
  logic signed [VW-1:0]              res;
  logic signed [VW:0]                v_sum, x_sum;

  assign uwc = dsi_pkg::ucode(upc);

  assign x_ext   = {{(VW-DW){x[DW-1]}}, x};
  assign v_ext   = {{(VW-DW){v[DW-1]}}, v};
  assign tgt_ext = {{(VW-DW){tgt[DW-1]}}, tgt};
  assign diff     = tgt_ext - x_ext;
  assign acc_diff = t2 - d2;
  assign k_inc    = k + dsi_pkg::STEP_W'(1);

  always_comb begin
    unique case (uwc.src)
      dsi_pkg::SRC_W:  src_val = w;
      dsi_pkg::SRC_T1: src_val = t1;
      dsi_pkg::SRC_V:  src_val = v_ext;
      dsi_pkg::SRC_D1: src_val = d1;
      default:         src_val = w;
    endcase
  end

  assign src_abs = src_val[VW-1] ? (VW'(0) - src_val) : src_val;

  always_comb begin
    unique case (uwc.mb)
      dsi_pkg::MB_OMEGA: mul_b = MW'(om);
      dsi_pkg::MB_ZETA:  mul_b = MW'(ze);
      dsi_pkg::MB_H:     mul_b = MW'(frame.h);
      default:           mul_b = '0;
    endcase
  end

  // The magnitude is multiplied in two halves on one shared multiplier.
  assign mul_a = (uwc.act == dsi_pkg::ACT_MHI) ? MW'(mag[VW-1:MW]) : mag[MW-1:0];
  assign prod  = (2*MW)'(mul_a) * (2*MW)'(mul_b);

  always_comb begin
    unique case (uwc.sh)
      dsi_pkg::SH_14: acc_sh = acc >> 14;
      dsi_pkg::SH_11: acc_sh = acc >> 11;
      dsi_pkg::SH_32: acc_sh = acc >> 32;
      default:        acc_sh = acc;
    endcase
  end

  assign res_mag = acc_sh[VW-1:0];
  assign res     = sgn ? (VW'(0) - res_mag) : res_mag;
  assign v_sum   = {v_ext[VW-1], v_ext} + {res[VW-1], res};
  assign x_sum   = {x_ext[VW-1], x_ext} + {res[VW-1], res};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      upc  <= '0;
    end else if (busy) begin
      unique case (uwc.act)
        dsi_pkg::ACT_CHK: begin
          upc <= frame.zero ? uwc.target : upc + dsi_pkg::UPC_W'(1);
        end
        dsi_pkg::ACT_LOOP: begin
          upc <= (k_inc != frame.steps) ? uwc.target : upc + dsi_pkg::UPC_W'(1);
        end
        dsi_pkg::ACT_DONE: begin
          if (done_ready) begin
            busy <= 1'b0;
            upc  <= '0;
          end
        end
        default: begin
          upc <= upc + dsi_pkg::UPC_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= position;
      v    <= velocity;
      tgt  <= target;
      om   <= stiffness_omega;
      ze   <= damping_ratio;
      last <= last_in_batch;
      k    <= '0;
    end else if (busy) begin
      unique case (uwc.act)
        dsi_pkg::ACT_DIFF: w <= diff;
        dsi_pkg::ACT_SUB:  w <= acc_diff;
        dsi_pkg::ACT_LOAD: begin
          sgn <= src_val[VW-1];
          mag <= src_abs;
        end
        dsi_pkg::ACT_MLO:  acc <= dsi_pkg::ACC_W'(prod);
        dsi_pkg::ACT_MHI:  acc <= acc + {prod[VW-1:0], MW'(0)};
        dsi_pkg::ACT_WB: begin
          unique case (uwc.dst)
            dsi_pkg::DST_T1: t1 <= res;
            dsi_pkg::DST_T2: t2 <= res;
            dsi_pkg::DST_D1: d1 <= res;
            dsi_pkg::DST_D2: d2 <= res;
            dsi_pkg::DST_V:  v  <= sat(v_sum);
            dsi_pkg::DST_X:  x  <= sat(x_sum);
            default: begin
            end
          endcase
        end
        dsi_pkg::ACT_LOOP: k <= k_inc;
        default: begin
        end
      endcase
    end
  end

  assign done_valid   = busy && (uwc.act == dsi_pkg::ACT_DONE);
  assign new_position = x;
  assign new_velocity = v;
  assign batch_end    = last;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("Spring core started while a spring is still in work.");

  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> upc <= dsi_pkg::UA_DONE)
    else $error("Step counter ran past the end of the program.");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    busy && !frame.zero |-> k <= frame.steps)
    else $error("Substep count exceeded the frame's substep total.");

endmodule

/* hw/rtl/damped_spring_integrator.sv */
// Channel | Dir | Handshake                    | Payload
// s_axis  | in  | s_axis_tvalid, s_axis_tready | spring state, stiffness, damping, tlast
// m_axis  | out | m_axis_tvalid, m_axis_tready | new position, new velocity, tlast
// cfg     | in  | cfg_valid, cfg_ready         | frame_time, unsigned Q0.24 seconds
//
// One spring runs the microcode loop once per substep, the substep count being 1 to 32,
// on the one shared 32 by 32 multiplier; a zero frame time skips the loop.
// A frame time write goes ahead of a waiting request and then holds off requests while
// the substep length is divided.
// Reset is synchronous and leaves a zero frame time, so springs pass through unchanged.
// A finished result waits in the output register while the next request is accepted.
module damped_spring_integrator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // position, velocity, target, stiffness_omega, damping_ratio
  input  logic [dsi_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // new_position, new_velocity
  output logic [dsi_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dsi_pkg::FT_W-1:0]             cfg_data
);

  localparam int DW = dsi_pkg::DATA_W;
  localparam int OM_LO = 3 * DW;
  localparam int ZE_LO = OM_LO + dsi_pkg::OMEGA_W;

  logic                   core_busy;
  logic                   div_busy;
  logic                   start;
  logic                   cfg_write;
  logic                   done_valid;
  logic                   done_ready;
  logic signed [DW-1:0]   new_position;
  logic signed [DW-1:0]   new_velocity;
  logic                   batch_end;
  dsi_pkg::frame_t        frame;

  assign s_axis_tready = !core_busy && !div_busy && !cfg_valid;
  assign cfg_ready     = !core_busy && !div_busy;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign cfg_write     = cfg_valid && cfg_ready;
  assign done_ready    = !m_axis_tvalid || m_axis_tready;

  dsi_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_write),
    .frame_time (cfg_data),
    .busy       (div_busy),
    .frame      (frame)
  );

  dsi_core u_core (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .position        (s_axis_tdata[DW-1:0]),
    .velocity        (s_axis_tdata[2*DW-1:DW]),
    .target          (s_axis_tdata[3*DW-1:2*DW]),
    .stiffness_omega (s_axis_tdata[ZE_LO-1:OM_LO]),
    .damping_ratio   (s_axis_tdata[dsi_pkg::IN_TDATA_W-1:ZE_LO]),
    .last_in_batch   (s_axis_tlast),
    .frame           (frame),
    .busy            (core_busy),
    .done_valid      (done_valid),
    .done_ready      (done_ready),
    .new_position    (new_position),
    .new_velocity    (new_velocity),
    .batch_end       (batch_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done_valid && done_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      m_axis_tdata <= {new_velocity, new_position};
      m_axis_tlast <= batch_end;
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (rst) !(core_busy && div_busy))
    else $error("Substep division ran while a spring was in work.");

endmodule
